>>> src/bwrc_pkg.sv
// Shared types, constants and the modular add used by the returning walk counter.
// Depends on nothing; every other file of the block imports it.
package bwrc_pkg;

  localparam int unsigned DATA_W        = 30;
  localparam int unsigned STEP_W        = 9;
  localparam int unsigned LEN_W         = 16;
  localparam int unsigned DEF_MAX_STEPS = 511;

  localparam logic [DATA_W-1:0] WALK_MOD = DATA_W'(1000000007);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_LOAD,
    ST_SWEEP,
    ST_RESULT
  } state_t;

  // Both operands must already be below the modulus.
  function automatic logic [DATA_W-1:0] mod_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, WALK_MOD}) begin
      s = s - {1'b0, WALK_MOD};
    end
    return s[DATA_W-1:0];
  endfunction

endpackage

>>> src/bwrc_row_mem.sv
// Row of walk counts: one write port and one registered read port.
// A read of the entry written in the same cycle returns the new data.
// Depends on bwrc_pkg for the word width.
module bwrc_row_mem #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [bwrc_pkg::DATA_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [bwrc_pkg::DATA_W-1:0] rdata
);
  import bwrc_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata_r <= wdata;
      end else begin
        rdata_r <= mem[raddr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/bounded_walk_return_count.sv
// Top level of the returning walk counter: control sequencer, sweep datapath
// and result register. Depends on bwrc_pkg and bwrc_row_mem.
//
// Usage: one input word carries a step count and a line length; the block
// answers each one with exactly one output word, the number of walks of that
// many moves (left, right or stay) that start and end at position 0 and never
// leave positions 0 .. min(line_length-1, step_count), modulo 1000000007.
// Both channels use valid/ready. A step count above MAX_STEPS is clamped to
// MAX_STEPS, and a line length of zero counts as one.
//
// Schedule: with L = min(line_length-1, steps) and S the clamped step count,
// entries 0 .. L of the row are initialized, then the row is swept S times,
// one row entry per cycle through the row memory's single port pair. Each
// sweep is a load state for entry 0 and a sweep state per position 0 .. L.
// Entry 0 is read in the last of those states and registered in the row
// memory; the result state moves it into the output register, and the
// sequencer then returns to idle. One item is worked on at a time.
//
// The result sits in an output register, so a new word is accepted as soon
// as the previous one has been computed, even if its result is still waiting
// for the receiver. If the receiver stalls, the finished next result holds in
// the sequencer until the output register frees up. Reset idles the sequencer
// and empties the output register; the row memory needs no clearing, since
// every item rewrites the entries it uses before reading them.
module bounded_walk_return_count #(
  parameter int unsigned MAX_STEPS = bwrc_pkg::DEF_MAX_STEPS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bwrc_pkg::STEP_W-1:0] in_step_count,
  input  logic [bwrc_pkg::LEN_W-1:0]  in_line_length,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bwrc_pkg::DATA_W-1:0] out_walk_count
);
  import bwrc_pkg::*;

  localparam int unsigned DEPTH = MAX_STEPS + 1;
  localparam int unsigned AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;

  state_t state_r, state_nxt;

  logic [AW-1:0]     steps_r, steps_nxt;     // clamped step count
  logic [AW-1:0]     last_r, last_nxt;       // last row position in use
  logic [AW-1:0]     step_r, step_nxt;       // sweeps completed
  logic [AW-1:0]     pos_r, pos_nxt;         // current row position
  logic [DATA_W-1:0] here_r, here_nxt;       // old value of current entry
  logic [DATA_W-1:0] left_r, left_nxt;       // old value of left neighbor
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  logic [AW-1:0]     steps_in, len_last_in;
  logic [LEN_W-1:0]  len_last;
  logic [AW:0]       ahead_addr;
  logic [DATA_W-1:0] right_val, new_val;

  bwrc_row_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_row_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Clamp the step count and find the last position a walk can reach.
  always_comb begin
    if (32'(in_step_count) > 32'(MAX_STEPS)) begin
      steps_in = AW'(MAX_STEPS);
    end else begin
      steps_in = AW'(in_step_count);
    end
    len_last = (in_line_length == '0) ? '0 : in_line_length - LEN_W'(1);
    if (32'(len_last) > 32'(steps_in)) begin
      len_last_in = steps_in;
    end else begin
      len_last_in = AW'(len_last);
    end
  end

  // Three-term neighbor sum; the right neighbor is absent at the last position.
  assign right_val  = (pos_r < last_r) ? mem_rdata : '0;
  assign new_val    = mod_add(mod_add(here_r, left_r), right_val);
  assign ahead_addr = {1'b0, pos_r} + (AW+1)'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steps_r    <= steps_nxt;
    last_r     <= last_nxt;
    step_r     <= step_nxt;
    pos_r      <= pos_nxt;
    here_r     <= here_nxt;
    left_r     <= left_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    steps_nxt     = steps_r;
    last_nxt      = last_r;
    step_nxt      = step_r;
    pos_nxt       = pos_r;
    here_nxt      = here_r;
    left_nxt      = left_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    in_ready      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          steps_nxt = steps_in;
          last_nxt  = len_last_in;
          pos_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_INIT;
        end
      end

      // Write one at position 0 and zero up to the last position.
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = (pos_r == '0) ? DATA_W'(1) : '0;
        if (pos_r == last_r) begin
          mem_re    = 1'b1;
          mem_raddr = '0;
          state_nxt = (steps_r == '0) ? ST_RESULT : ST_LOAD;
        end else begin
          pos_nxt = pos_r + AW'(1);
        end
      end

      // Entry 0 has arrived; fetch entry 1, if it is in use, ahead of the sweep.
      ST_LOAD: begin
        here_nxt = mem_rdata;
        left_nxt = '0;
        pos_nxt  = '0;
        if (last_r != '0) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(1);
        end
        state_nxt = ST_SWEEP;
      end

      // Each cycle the read data is the old right neighbor of pos_r. The
      // read runs one entry ahead of the write, so old values are never lost.
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_wdata = new_val;
        left_nxt  = here_r;
        here_nxt  = right_val;
        if (pos_r != last_r) begin
          pos_nxt = pos_r + AW'(1);
          if (ahead_addr <= {1'b0, last_r}) begin
            mem_re    = 1'b1;
            mem_raddr = ahead_addr[AW-1:0];
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = '0;
          step_nxt  = step_r + AW'(1);
          if (step_r + AW'(1) == steps_r) begin
            state_nxt = ST_RESULT;
          end else begin
            state_nxt = ST_LOAD;
          end
        end
      end

      // Entry 0 is the answer; hold it until the output register is free.
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = mem_rdata;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_walk_count = out_data_r;

  // The sweep position never runs past the last position in use.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP || state_r == ST_INIT) |-> (pos_r <= last_r))
    else $error("row position past last entry");

  // The row is only written while initializing or sweeping.
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_INIT || state_r == ST_SWEEP))
    else $error("row write outside init or sweep");

  // A new result only appears after the result state loaded it.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESULT))
    else $error("result appeared without a finished item");

  // Results held in the sequencer never overwrite a waiting result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("waiting result overwritten");

endmodule
